>>> design/assert_macros.svh
// Assertion macros used by the checker file of the keystream byte cipher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, clocked on the rising edge and switched off while reset is held.
`define KBC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Concurrent assertion, clocked on the rising edge and checked through reset as well.
`define KBC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/kbc_pkg.sv
// Package of types, constants and register codes for the keystream byte cipher.
package kbc_pkg;

    localparam int unsigned KeyWords   = 4;
    localparam int unsigned PosBits    = 5;
    localparam int unsigned AddrBits   = 6;

    localparam logic [63:0] SEED_FALLBACK = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [3:0]  BLOCK_BYTES   = 4'd8;

    // Register index, taken from paddr[5:3]
    localparam logic [2:0] REG_MODE  = 3'd0;
    localparam logic [2:0] REG_DIR   = 3'd1;
    localparam logic [2:0] REG_KEY0  = 3'd2;
    localparam logic [2:0] REG_KEY1  = 3'd3;
    localparam logic [2:0] REG_KEY2  = 3'd4;
    localparam logic [2:0] REG_KEY3  = 3'd5;

    typedef enum logic [1:0] {
        MODE_PASS = 2'd0,
        MODE_XOR  = 2'd1,
        MODE_ADD  = 2'd2
    } t_mode;

    typedef struct packed {
        t_mode                     mode;
        logic                      decrypt;
        logic [KeyWords-1:0][63:0] key;
    } t_cfg;

    typedef struct packed {
        logic start;
        logic advance;
    } t_gen_ctrl;

endpackage

>>> design/keystream_byte_cipher_top.sv
// Top level of the keystream byte cipher: stream ports, register port and result register.
//
// One data byte enters per beat on the slave stream (s_axis_*). tdata carries the byte;
// tuser[0] is the start flag, which reseeds the generator from key words 0 and 1 and
// clears the stream position before that byte is handled. Each input beat yields exactly
// one output beat on the master stream (m_axis_*) carrying the transformed byte.
// Modes 0 and 3 pass bytes through, mode 1 XORs them with the xorshift128+ keystream, and
// mode 2 adds (or, with the decrypt bit set, subtracts) the key byte at position mod 32.
// The registers sit on the APB port at byte addresses 0, 8, ..., 40 and should only be
// written while no beat is in flight.
// The result is registered: a byte accepted at one edge is offered on the output from the
// next cycle. Throughput is one byte per cycle while the receiver keeps up; the generator
// step and its 64-bit add are combinational between acceptance and the result register.
// When the receiver stalls, the result is held in the output register and a new beat is
// taken only in the cycle in which the held one leaves, so the input backs up at once.
// Synchronous reset clears the configuration registers, the generator state and the output valid.
module keystream_byte_cipher_top
    import kbc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input stream
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]          s_axis_tuser,   // [0] start_stream
    // Output stream
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [7:0]          m_axis_tdata,   // [7:0] result_byte
    // Register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [AddrBits-1:0] paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);

    t_cfg      cfg;
    t_gen_ctrl gen_ctrl;
    logic      accept;
    logic [7:0] ks_byte, key_byte, n_result;

    logic       r_out_valid;
    logic [7:0] r_out_data;

    kbc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The input side is free whenever the result register is empty or draining.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // The generator only moves in keystream mode, but a start reseeds it in any mode.
    assign gen_ctrl.start   = accept && s_axis_tuser[0];
    assign gen_ctrl.advance = accept && (cfg.mode == MODE_XOR);

    kbc_keygen u_keygen (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (gen_ctrl),
        .i_seed0   (cfg.key[0]),
        .i_seed1   (cfg.key[1]),
        .o_ks_byte (ks_byte)
    );

    kbc_keyrep u_keyrep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_start    (gen_ctrl.start),
        .i_key      (cfg.key),
        .o_key_byte (key_byte)
    );

    always_comb begin
        unique case (cfg.mode)
            MODE_XOR: n_result = s_axis_tdata ^ ks_byte;
            MODE_ADD: n_result = cfg.decrypt ? (s_axis_tdata - key_byte)
                                             : (s_axis_tdata + key_byte);
            default:  n_result = s_axis_tdata;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

>>> design/kbc_cfg.sv
// Configuration register file of the keystream byte cipher, written and read over APB.
module kbc_cfg
    import kbc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [AddrBits-1:0] paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    output t_cfg                o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[AddrBits-1:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MODE: r_cfg.mode    <= t_mode'(pwdata[1:0]);
                REG_DIR:  r_cfg.decrypt <= pwdata[0];
                REG_KEY0: r_cfg.key[0]  <= pwdata;
                REG_KEY1: r_cfg.key[1]  <= pwdata;
                REG_KEY2: r_cfg.key[2]  <= pwdata;
                REG_KEY3: r_cfg.key[3]  <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MODE: prdata = {62'd0, r_cfg.mode};
            REG_DIR:  prdata = {63'd0, r_cfg.decrypt};
            REG_KEY0: prdata = r_cfg.key[0];
            REG_KEY1: prdata = r_cfg.key[1];
            REG_KEY2: prdata = r_cfg.key[2];
            REG_KEY3: prdata = r_cfg.key[3];
            default:  prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/kbc_keyrep.sv
// Stream position counter and repeating-key byte selection.
module kbc_keyrep
    import kbc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic                      i_start,
    input  logic [KeyWords-1:0][63:0] i_key,
    output logic [7:0]                o_key_byte
);

    logic [PosBits-1:0] r_pos;
    logic [PosBits-1:0] pos_eff;
    logic [63:0]        word;

    assign pos_eff    = i_start ? '0 : r_pos;
    assign word       = i_key[pos_eff[PosBits-1:3]];
    assign o_key_byte = word[{pos_eff[2:0], 3'b000} +: 8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_accept) begin
            r_pos <= pos_eff + 1'b1;
        end
    end

endmodule

>>> design/kbc_keygen.sv
// Xorshift128+ keystream generator, handing out each 64-bit output low byte first.
module kbc_keygen
    import kbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_gen_ctrl   i_ctrl,
    input  logic [63:0] i_seed0,
    input  logic [63:0] i_seed1,
    output logic [7:0]  o_ks_byte
);

    logic [63:0] r_a, r_b, r_blk;
    logic [3:0]  r_left;
    logic [63:0] n_a, n_b, n_blk;
    logic [3:0]  n_left;

    logic        seed_zero, need;
    logic [63:0] a_eff, b_eff, blk_eff, x, step_b, step_blk, cur_blk;
    logic [3:0]  left_eff;

    always_comb begin
        seed_zero = (i_seed0 | i_seed1) == 64'd0;
        a_eff     = i_ctrl.start ? i_seed0 : r_a;
        b_eff     = i_ctrl.start ? (seed_zero ? SEED_FALLBACK : i_seed1) : r_b;
        blk_eff   = i_ctrl.start ? 64'd0 : r_blk;
        left_eff  = i_ctrl.start ? 4'd0 : r_left;
        need      = left_eff == 4'd0;

        // One generator step, used only when the current block is spent.
        x        = a_eff ^ (a_eff << 23);
        step_b   = x ^ b_eff ^ (x >> 17) ^ (b_eff >> 26);
        step_blk = step_b + b_eff;
        cur_blk  = need ? step_blk : blk_eff;

        n_a    = a_eff;
        n_b    = b_eff;
        n_blk  = blk_eff;
        n_left = left_eff;
        if (i_ctrl.advance) begin
            n_a    = need ? b_eff : a_eff;
            n_b    = need ? step_b : b_eff;
            n_blk  = cur_blk >> 8;
            n_left = (need ? BLOCK_BYTES : left_eff) - 4'd1;
        end
    end

    assign o_ks_byte = cur_blk[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a    <= '0;
            r_b    <= '0;
            r_blk  <= '0;
            r_left <= '0;
        end else if (i_ctrl.start || i_ctrl.advance) begin
            r_a    <= n_a;
            r_b    <= n_b;
            r_blk  <= n_blk;
            r_left <= n_left;
        end
    end

endmodule

>>> design/kbc_checker.sv
// Port-level checker for the keystream byte cipher, bound to its top level.
`include "assert_macros.svh"

module kbc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       pready
);

    `KBC_ASSERT(a_pready_high, i_clk, i_rst_n, pready, "pready dropped")
    `KBC_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !m_axis_tvalid |-> s_axis_tready, "input blocked with empty output")
    `KBC_ASSERT(a_beat_gives_result, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid, "accepted beat produced no result")
    `KBC_ASSERT(a_no_invented, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tready && !(s_axis_tvalid && s_axis_tready)) |=> !m_axis_tvalid, "result appeared without an input beat")
    `KBC_ASSERT(a_stall_holds, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")

endmodule

bind keystream_byte_cipher_top kbc_checker u_kbc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);
